// ===== hw/rtl/aip_pkg.sv =====
// Shared types and constants of the ASCII integer parser.
package aip_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned DATA_W  = 32;

  // Register indexes (byte address bits [3:2])
  localparam logic [1:0] REG_BASE_MODE   = 2'd0;
  localparam logic [1:0] REG_SIGNED_MODE = 2'd1;
  localparam logic [1:0] REG_SKIP_SPACE  = 2'd2;

  // base_mode register codes
  localparam logic [1:0] BM_DETECT = 2'd0;
  localparam logic [1:0] BM_OCT    = 2'd1;
  localparam logic [1:0] BM_DEC    = 2'd2;
  localparam logic [1:0] BM_HEX    = 2'd3;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_NODIG = 3'd1,
    ST_RANGE = 3'd2,
    ST_EMPTY = 3'd3,
    ST_SIGN  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_NUM  = 2'd1,
    PH_ZERO = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    B_OCT = 2'd0,
    B_DEC = 2'd1,
    B_HEX = 2'd2
  } base_e;

  typedef struct packed {
    logic [1:0] base_mode;
    logic       signed_mode;
    logic       skip_space;
  } cfg_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    status_e            status;
    logic               last;
  } result_t;

  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

// ===== hw/rtl/aip_if.sv =====
// Valid/ready channel interfaces for characters in and results out.
interface aip_in_if;
  logic                        valid;
  logic                        ready;
  logic [aip_pkg::CHAR_W-1:0]  char_in;
  logic                        end_of_input;

  modport source (output valid, char_in, end_of_input, input ready);
  modport sink (input valid, char_in, end_of_input, output ready);
endinterface

interface aip_out_if;
  logic                        valid;
  logic                        ready;
  logic [aip_pkg::VALUE_W-1:0] value;
  logic [2:0]                  status;
  logic                        last_of_item;

  modport source (output valid, value, status, last_of_item, input ready);
  modport sink (input valid, value, status, last_of_item, output ready);
endinterface

// ===== hw/rtl/aip_cfg.sv =====
// APB-style configuration registers of the parser.
module aip_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [aip_pkg::ADDR_W-1:0]   paddr,
  input  logic [aip_pkg::DATA_W-1:0]   pwdata,
  output logic [aip_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output aip_pkg::cfg_t                cfg_o
);
  import aip_pkg::*;

  cfg_t       cfg_q;
  logic [1:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_mode   <= BM_DETECT;
      cfg_q.signed_mode <= 1'b1;
      cfg_q.skip_space  <= 1'b1;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_BASE_MODE:   cfg_q.base_mode   <= pwdata[1:0];
        REG_SIGNED_MODE: cfg_q.signed_mode <= pwdata[0];
        REG_SKIP_SPACE:  cfg_q.skip_space  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_BASE_MODE:   prdata = DATA_W'(cfg_q.base_mode);
      REG_SIGNED_MODE: prdata = DATA_W'(cfg_q.signed_mode);
      REG_SKIP_SPACE:  prdata = DATA_W'(cfg_q.skip_space);
      default:         prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/aip_core.sv =====
// Input register, parse state and combinational character step.
module aip_core #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  aip_in_if.sink         in_if,
  input  aip_pkg::cfg_t  cfg_i,
  input  logic           room_i,
  output aip_pkg::push_t push_o
);
  import aip_pkg::*;

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned PW = WORD_BITS + 5;
  localparam int unsigned VW = (WORD_BITS > VALUE_W) ? WORD_BITS : VALUE_W;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_A_UP  = 8'h41;
  localparam logic [7:0] CH_F_UP  = 8'h46;
  localparam logic [7:0] CH_A_LO  = 8'h61;
  localparam logic [7:0] CH_F_LO  = 8'h66;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_X_LO  = 8'h78;

  // {valid, digit} of a character in a base
  function automatic logic [4:0] digit_of(input logic [7:0] c, input base_e b);
    logic [4:0] r;
    r = '0;
    if (b == B_OCT) begin
      if (c >= CH_0 && c <= CH_7) r = {1'b1, 4'(c - CH_0)};
    end else begin
      if (c >= CH_0 && c <= CH_9) begin
        r = {1'b1, 4'(c - CH_0)};
      end else if (b == B_HEX && c >= CH_A_LO && c <= CH_F_LO) begin
        r = {1'b1, 4'(c - CH_A_LO + 8'd10)};
      end else if (b == B_HEX && c >= CH_A_UP && c <= CH_F_UP) begin
        r = {1'b1, 4'(c - CH_A_UP + 8'd10)};
      end
    end
    return r;
  endfunction

  // Input register
  logic       in_vld_q;
  logic [7:0] char_q;
  logic       eoi_q;
  logic       proc;

  // Parse state
  phase_e       phase_q, phase_d;
  logic [W-1:0] acc_q, acc_d;
  logic         ovf_q, ovf_d;
  logic         neg_q, neg_d;
  base_e        base_q, base_d;

  assign proc        = in_vld_q && room_i;
  assign in_if.ready = !in_vld_q || proc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_if.ready) begin
      in_vld_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.ready && in_if.valid) begin
      char_q <= in_if.char_in;
      eoi_q  <= in_if.end_of_input;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      acc_q   <= '0;
      ovf_q   <= 1'b0;
      neg_q   <= 1'b0;
      base_q  <= B_DEC;
    end else begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      ovf_q   <= ovf_d;
      neg_q   <= neg_d;
      base_q  <= base_d;
    end
  end

  // Accumulate: acc * radix + digit, overflow when the top bits are set
  logic [4:0]    acc_dig;
  logic [PW-1:0] prod;
  logic [PW-1:0] sum;
  logic [W-1:0]  acc_next;
  logic          acc_ovf;

  assign acc_dig = (phase_q == PH_ZERO) ? digit_of(char_q, B_OCT) : digit_of(char_q, base_q);

  always_comb begin
    case (base_q)
      B_OCT:   prod = PW'(acc_q) << 3;
      B_HEX:   prod = PW'(acc_q) << 4;
      default: prod = (PW'(acc_q) << 3) + (PW'(acc_q) << 1);
    endcase
  end

  assign sum      = prod + PW'(acc_dig[3:0]);
  assign acc_ovf  = |sum[PW-1:W];
  assign acc_next = sum[W-1:0];

  // Range check of the number that ends now
  logic [W-1:0]  fin_v;
  status_e       fin_st;
  logic [VW-1:0] fin_ext;

  always_comb begin
    fin_v  = '0;
    fin_st = ST_OK;
    if (ovf_q) begin
      fin_st = ST_RANGE;
    end else if (cfg_i.signed_mode) begin
      if (neg_q) begin
        if (!acc_q[W-1] || acc_q[W-2:0] == '0) fin_v = '0 - acc_q;
        else fin_st = ST_RANGE;
      end else begin
        if (!acc_q[W-1]) fin_v = acc_q;
        else fin_st = ST_RANGE;
      end
    end else begin
      if (neg_q) fin_st = ST_SIGN;
      else fin_v = acc_q;
    end
  end

  assign fin_ext = VW'(fin_v);

  // Start of a number from an idle parser
  logic       s_emit;
  status_e    s_st;
  logic       s_begin;
  logic       s_zero;
  logic       s_neg;
  base_e      s_base;
  logic [3:0] s_dig;
  logic [4:0] s_dd;
  logic       is_space;
  logic       is_sign;

  assign is_space = cfg_i.skip_space &&
                    (char_q == CH_SPACE || (char_q >= CH_TAB && char_q <= CH_CR));
  assign is_sign  = (char_q == CH_PLUS) || (char_q == CH_MINUS);

  always_comb begin
    s_emit  = 1'b0;
    s_st    = ST_OK;
    s_begin = 1'b0;
    s_zero  = 1'b0;
    s_neg   = 1'b0;
    s_base  = B_DEC;
    s_dig   = '0;
    s_dd    = '0;
    if (is_space) begin
      s_emit = 1'b0;
    end else if (is_sign) begin
      if ((cfg_i.base_mode != BM_DETECT && cfg_i.base_mode != BM_DEC) ||
          (char_q == CH_MINUS && !cfg_i.signed_mode)) begin
        s_emit = 1'b1;
        s_st   = ST_SIGN;
      end else begin
        s_begin = 1'b1;
        s_neg   = (char_q == CH_MINUS);
      end
    end else if (cfg_i.base_mode == BM_DETECT && char_q == CH_0) begin
      s_begin = 1'b1;
      s_zero  = 1'b1;
      s_base  = B_OCT;
    end else begin
      case (cfg_i.base_mode)
        BM_OCT:  s_base = B_OCT;
        BM_HEX:  s_base = B_HEX;
        default: s_base = B_DEC;
      endcase
      s_dd = digit_of(char_q, s_base);
      if (!s_dd[4]) begin
        s_emit = 1'b1;
        s_st   = ST_NODIG;
      end else begin
        s_begin = 1'b1;
        s_dig   = s_dd[3:0];
      end
    end
  end

  // Step: finish and/or start, or extend the current number
  logic    fin_sel;
  logic    alt_sel;
  status_e alt_st;
  logic    run_start;

  always_comb begin
    phase_d   = phase_q;
    acc_d     = acc_q;
    ovf_d     = ovf_q;
    neg_d     = neg_q;
    base_d    = base_q;
    fin_sel   = 1'b0;
    alt_sel   = 1'b0;
    alt_st    = ST_OK;
    run_start = 1'b0;
    if (proc) begin
      if (eoi_q) begin
        if (phase_q == PH_IDLE) begin
          alt_sel = 1'b1;
          alt_st  = ST_EMPTY;
        end else begin
          fin_sel = 1'b1;
          phase_d = PH_IDLE;
          acc_d   = '0;
          ovf_d   = 1'b0;
          neg_d   = 1'b0;
        end
      end else if (phase_q == PH_IDLE) begin
        run_start = 1'b1;
      end else if (phase_q == PH_ZERO && (char_q == CH_X_LO || char_q == CH_X_UP)) begin
        base_d  = B_HEX;
        phase_d = PH_NUM;
      end else if (acc_dig[4]) begin
        acc_d   = acc_next;
        ovf_d   = ovf_q | acc_ovf;
        phase_d = PH_NUM;
      end else begin
        fin_sel   = 1'b1;
        run_start = 1'b1;
      end

      if (run_start) begin
        alt_sel = s_emit;
        alt_st  = s_st;
        ovf_d   = 1'b0;
        if (s_begin) begin
          phase_d = s_zero ? PH_ZERO : PH_NUM;
          acc_d   = W'(s_dig);
          neg_d   = s_neg;
          base_d  = s_base;
        end else begin
          phase_d = PH_IDLE;
          acc_d   = '0;
          neg_d   = 1'b0;
        end
      end
    end
  end

  // Pack the results in order: finished number first
  result_t fin_res;
  result_t alt_res;

  always_comb begin
    fin_res.value  = fin_ext[VALUE_W-1:0];
    fin_res.status = fin_st;
    fin_res.last   = !alt_sel;
    alt_res.value  = '0;
    alt_res.status = alt_st;
    alt_res.last   = 1'b1;
    push_o.cnt     = {1'b0, fin_sel} + {1'b0, alt_sel};
    push_o.r0      = fin_sel ? fin_res : alt_res;
    push_o.r1      = alt_res;
  end

endmodule

// ===== hw/rtl/aip_fifo.sv =====
// Four-entry result queue that drives the output channel.
module aip_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  aip_pkg::push_t push_i,
  output logic           room_o,
  aip_out_if.source      out_if
);
  import aip_pkg::*;

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = PTR_W + 1;

  result_t            mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_q, rd_q;
  logic [CNT_W-1:0]   count_q;
  logic               pop;
  result_t            head;

  assign pop    = out_if.valid && out_if.ready;
  assign room_o = count_q <= CNT_W'(DEPTH - 2);
  assign head   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) mem_q[wr_q] <= push_i.r0;
    if (push_i.cnt == 2'd2) mem_q[PTR_W'(wr_q + 1'b1)] <= push_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= PTR_W'(wr_q + PTR_W'(push_i.cnt));
      rd_q    <= PTR_W'(rd_q + PTR_W'(pop));
      count_q <= CNT_W'(count_q + CNT_W'(push_i.cnt) - CNT_W'(pop));
    end
  end

  assign out_if.valid        = count_q != '0;
  assign out_if.value        = head.value;
  assign out_if.status       = head.status;
  assign out_if.last_of_item = head.last;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("result queue count beyond depth");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.cnt != 2'd0 |-> room_o)
    else $error("results pushed without room");

  a_cnt_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.cnt != 2'd3)
    else $error("more than two results from one item");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.cnt == 2'd1 |-> push_i.r0.last) and
    (push_i.cnt == 2'd2 |-> (push_i.r1.last && !push_i.r0.last)))
    else $error("last flag not on final result of item");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && push_i.cnt == 2'd0) |=> count_q == CNT_W'($past(count_q) - 1'b1))
    else $error("queue count did not drop on transfer");

endmodule

// ===== hw/rtl/ascii_integer_parser.sv =====
// Top level of the streaming ASCII integer parser.
// The parser takes one character (or an end-of-input mark) per transfer on
// in_if and produces parsed integers on out_if. Numbers have an optional sign
// (decimal only), a fixed octal, decimal or hex base, or a base detected from
// a leading 0 or 0x. Digits accumulate into WORD_BITS bits with a sticky
// overflow flag; the range check (signed or unsigned, per signed_mode) is done
// when the number ends. The character that ends a number is examined again as
// the start of the next one, so one transfer can give up to two results; the
// last of them carries last_of_item. Rate: one input transfer per clock while
// the result queue has room. An accepted character sits in an input register,
// is parsed from there and its results land in a four-entry result queue that
// drives out_if. The input side stalls only when the result queue holds more
// than two entries, i.e. when the sink drains slower than results are made; an
// item that yields two results uses two output transfers. Configuration goes
// through the APB-style port at byte addresses 0 (base_mode), 4 (signed_mode)
// and 8 (skip_space); write it only while no item is in flight.
module ascii_integer_parser #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [aip_pkg::ADDR_W-1:0]  paddr,
  input  logic [aip_pkg::DATA_W-1:0]  pwdata,
  output logic [aip_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  aip_in_if.sink                      in_if,
  aip_out_if.source                   out_if
);
  import aip_pkg::*;

  cfg_t  cfg;
  push_t push;
  logic  room;

  // Register block: hold base, sign and whitespace settings
  aip_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Parse one character per cycle; advance only when the queue has room
  // for the worst case of two results
  aip_core #(
    .WORD_BITS (WORD_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .cfg_i  (cfg),
    .room_i (room),
    .push_o (push)
  );

  // Result queue: decouple the sink from the parser
  aip_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .out_if (out_if)
  );

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the streaming ASCII integer parser.
`timescale 1ns / 1ps

module tb;
  import aip_pkg::*;

  // Cycles with no transfer or register access before the run is declared hung
  localparam int STALL_LIMIT = 2000;
  localparam int N_RUNS      = 9;
  localparam int RUN_ITEMS   = 90;

  // Characters the parser treats specially
  localparam logic [7:0] CH_0     = "0";
  localparam logic [7:0] CH_7     = "7";
  localparam logic [7:0] CH_9     = "9";
  localparam logic [7:0] CH_LA    = "a";
  localparam logic [7:0] CH_LF    = "f";
  localparam logic [7:0] CH_UA    = "A";
  localparam logic [7:0] CH_UF    = "F";
  localparam logic [7:0] CH_LX    = "x";
  localparam logic [7:0] CH_UX    = "X";
  localparam logic [7:0] CH_PLUS  = "+";
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_SP    = " ";
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;

  // Values around the signed and unsigned range edges and the overflow point
  localparam logic [63:0] EDGE_VALS [9] = '{
    64'h0, 64'h1, 64'h7FFF_FFFE, 64'h7FFF_FFFF, 64'h8000_0000,
    64'h8000_0001, 64'hFFFF_FFFF, 64'h1_0000_0000, 64'h1_9999_9999
  };

  // Register settings for the random runs; the last run is drawn at random
  localparam logic [1:0] RUN_BASE [N_RUNS] = '{
    BM_DEC, BM_HEX, BM_OCT, BM_DETECT, BM_HEX, BM_DEC, BM_OCT, BM_DETECT, BM_DETECT
  };
  localparam logic RUN_SIGNED [N_RUNS] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1};
  localparam logic RUN_SKIP [N_RUNS]   = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};

  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
  } char_item_t;

  logic clk_i;
  logic rst_ni;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  aip_in_if  in_if();
  aip_out_if out_if();

  ascii_integer_parser #(
    .WORD_BITS(32)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .in_if  (in_if),
    .out_if (out_if)
  );

  // Characters waiting to be sent and parse results still owed by the block
  char_item_t char_stream [$];
  result_t    due_results [$];

  // Register copy as the parser model sees it
  logic [1:0] cfg_base_mode;
  logic       cfg_signed;
  logic       cfg_skip;

  // Parser model state
  phase_e      num_phase;
  logic [31:0] num_acc;
  logic        num_ovf;
  logic        num_neg;
  base_e       num_base;

  // Results produced by the character being parsed (at most two)
  result_t res_buf [2];
  int      res_n;

  int  err_cnt;
  int  idle_cycles;
  int  send_gap;
  int  sink_gap;
  bit  no_idle;

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Parser model
  // ---------------------------------------------------------------------------

  // Digit value of c in base b, -1 when c is no digit of that base
  function automatic int digit_val(logic [7:0] c, base_e b);
    if (b == B_OCT) return (c >= CH_0 && c <= CH_7) ? int'(c - CH_0) : -1;
    if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
    if (b == B_HEX) begin
      if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
      if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
    end
    return -1;
  endfunction

  function automatic void add_result(logic [31:0] v, status_e s);
    if (res_n < 2) begin
      res_buf[res_n].value  = v;
      res_buf[res_n].status = s;
      res_buf[res_n].last   = 1'b0;
      res_n++;
    end
  endfunction

  // Shift in one digit; overflow is sticky once the exact value leaves 32 bits
  function automatic void push_digit(int unsigned d);
    logic [63:0] r;
    r = (num_base == B_OCT) ? 64'd8 : (num_base == B_HEX) ? 64'd16 : 64'd10;
    if ({32'd0, num_acc} > (64'hFFFF_FFFF - 64'(d)) / r) num_ovf = 1'b1;
    num_acc = 32'({32'd0, num_acc} * r + 64'(d));
  endfunction

  function automatic void open_number(base_e b, logic neg);
    num_acc   = '0;
    num_ovf   = 1'b0;
    num_neg   = neg;
    num_base  = b;
    num_phase = PH_NUM;
  endfunction

  // End the number: range check with the sign mode in force right now
  function automatic void close_number();
    logic [31:0] v;
    status_e     s;
    v = '0;
    s = ST_OK;
    if (num_ovf) begin
      s = ST_RANGE;
    end else if (cfg_signed) begin
      if (num_neg) begin
        if (num_acc <= 32'h8000_0000) v = 32'd0 - num_acc;
        else s = ST_RANGE;
      end else if (num_acc <= 32'h7FFF_FFFF) begin
        v = num_acc;
      end else begin
        s = ST_RANGE;
      end
    end else if (num_neg) begin
      s = ST_SIGN;
    end else begin
      v = num_acc;
    end
    add_result(v, s);
    num_phase = PH_IDLE;
    num_acc   = '0;
    num_ovf   = 1'b0;
    num_neg   = 1'b0;
  endfunction

  // Character seen while idle: skip it, open a number, or reject it
  function automatic void start_char(logic [7:0] c);
    int    d;
    base_e b;
    if (cfg_skip && (c == CH_SP || (c >= CH_TAB && c <= CH_CR))) return;
    if (c == CH_PLUS || c == CH_MINUS) begin
      // signs only in decimal, and minus only with the signed range check
      if ((cfg_base_mode != BM_DETECT && cfg_base_mode != BM_DEC) ||
          (c == CH_MINUS && !cfg_signed)) begin
        add_result('0, ST_SIGN);
      end else begin
        open_number(B_DEC, c == CH_MINUS);
      end
      return;
    end
    if (cfg_base_mode == BM_DETECT) begin
      // a leading zero may still turn into a hex prefix
      if (c == CH_0) begin
        open_number(B_OCT, 1'b0);
        num_phase = PH_ZERO;
        return;
      end
      b = B_DEC;
    end else begin
      b = (cfg_base_mode == BM_OCT) ? B_OCT : (cfg_base_mode == BM_DEC) ? B_DEC : B_HEX;
    end
    d = digit_val(c, b);
    if (d < 0) begin
      add_result('0, ST_NODIG);
    end else begin
      open_number(b, 1'b0);
      push_digit(d);
    end
  endfunction

  // Parse one accepted transfer and queue the results it owes
  function automatic void parse_char(logic [7:0] c, logic eoi);
    int      d;
    result_t r;
    res_n = 0;
    if (eoi) begin
      if (num_phase == PH_IDLE) add_result('0, ST_EMPTY);
      else close_number();
    end else if (num_phase == PH_IDLE) begin
      start_char(c);
    end else if (num_phase == PH_ZERO) begin
      d = digit_val(c, B_OCT);
      if (c == CH_LX || c == CH_UX) begin
        // the x is consumed; "0x" with no hex digit still reads as zero
        num_base  = B_HEX;
        num_phase = PH_NUM;
      end else if (d >= 0) begin
        push_digit(d);
        num_phase = PH_NUM;
      end else begin
        close_number();
        start_char(c);
      end
    end else begin
      d = digit_val(c, num_base);
      if (d >= 0) begin
        push_digit(d);
      end else begin
        // the terminator is looked at again as the start of the next number
        close_number();
        start_char(c);
      end
    end
    for (int i = 0; i < res_n; i++) begin
      r      = res_buf[i];
      r.last = (i == res_n - 1);
      due_results.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void push_char(logic [7:0] c, logic eoi);
    char_item_t it;
    it.ch  = c;
    it.eoi = eoi;
    char_stream.push_back(it);
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i], 1'b0);
  endfunction

  // Mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Append one token: usually a well-formed number in the current base with
  // random content and terminator, sometimes plain noise. Returns its length.
  function automatic int add_token();
    int unsigned radix;
    logic [63:0] v;
    logic [7:0]  digs [$];
    int          d;
    int          r;
    int          n0;
    n0 = char_stream.size();
    if ($urandom_range(0, 99) < 20) begin
      repeat ($urandom_range(1, 3))
        push_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      return char_stream.size() - n0;
    end
    repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0)
      push_char(($urandom_range(0, 3) == 0) ? CH_SP : 8'($urandom_range(9, 13)), 1'b0);
    radix = (cfg_base_mode == BM_OCT) ? 8 : (cfg_base_mode == BM_HEX) ? 16 : 10;
    if ($urandom_range(0, 9) < 3) begin
      push_char($urandom_range(0, 1) ? CH_MINUS : CH_PLUS, 1'b0);
    end else if (cfg_base_mode == BM_DETECT) begin
      case ($urandom_range(0, 2))
        0: begin
          radix = 8;
          push_char(CH_0, 1'b0);
        end
        1: begin
          radix = 16;
          push_char(CH_0, 1'b0);
          push_char($urandom_range(0, 1) ? CH_LX : CH_UX, 1'b0);
        end
        default: radix = 10;
      endcase
    end
    case ($urandom_range(0, 9))
      0, 1:    v = 64'($urandom_range(0, 999));
      2, 3:    v = EDGE_VALS[$urandom_range(0, 8)];
      4:       v = {$urandom, $urandom};
      default: v = 64'($urandom >> $urandom_range(0, 31));
    endcase
    do begin
      d = int'(v % radix);
      digs.push_front(d < 10 ? CH_0 + 8'(d) :
                      ($urandom_range(0, 1) ? CH_LA : CH_UA) + 8'(d - 10));
      v = v / radix;
    end while (v != 0);
    // hex prefix with no digits after it, or a redundant leading zero
    if (radix == 16 && digs.size() == 1 && digs[0] == CH_0 && $urandom_range(0, 1))
      digs.delete();
    else if (cfg_base_mode != BM_DETECT && $urandom_range(0, 7) == 0)
      digs.push_front(CH_0);
    foreach (digs[i]) push_char(digs[i], 1'b0);
    r = $urandom_range(0, 19);
    if (r < 7) push_char(CH_SP, 1'b0);
    else if (r < 11) push_char(8'($urandom_range(0, 255)), 1'b1);
    else push_char(8'($urandom_range(0, 255)), 1'b0);
    return char_stream.size() - n0;
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
    $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, exp_val, $time);
    err_cnt++;
  endtask

  // APB write with setup and access phases; the register takes it at the access edge
  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_BASE_MODE:   cfg_base_mode = data[1:0];
      REG_SIGNED_MODE: cfg_signed    = data[0];
      REG_SKIP_SPACE:  cfg_skip      = data[0];
      default: ;
    endcase
  endtask

  // Hold until every character is sent and every result is back, then wait
  // so the block can settle a character that owed nothing; a character still
  // offered counts as not yet sent
  task automatic drain();
    while (char_stream.size() != 0 || due_results.size() != 0 || in_if.valid)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Character driver: present the head of char_stream, drop it on transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        void'(char_stream.pop_front());
        send_gap = pick_gap();
      end
      if (in_if.valid && !in_if.ready) begin
        // hold the offered character until it is taken
      end else if (send_gap > 0) begin
        send_gap--;
        in_if.valid <= 1'b0;
      end else if (char_stream.size() > 0) begin
        in_if.valid        <= 1'b1;
        in_if.char_in      <= char_stream[0].ch;
        in_if.end_of_input <= char_stream[0].eoi;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result sink: stall ready at random after each transfer
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      sink_gap = 0;
    end else begin
      if (out_if.valid && out_if.ready) sink_gap = pick_gap();
      if (sink_gap > 0) begin
        sink_gap--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each result against the oldest one owed, then parse the
  // character taken at this edge. Results always trail their character through
  // the input register and the result queue, so checking first is safe.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    result_t got_exp;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (due_results.size() == 0) begin
          flag_mismatch("unexpected result value", out_if.value, '0);
        end else begin
          got_exp = due_results.pop_front();
          if (out_if.value !== got_exp.value)
            flag_mismatch("value", out_if.value, got_exp.value);
          if (out_if.status !== got_exp.status)
            flag_mismatch("status", 32'(out_if.status), 32'(got_exp.status));
          if (out_if.last_of_item !== got_exp.last)
            flag_mismatch("last_of_item", 32'(out_if.last_of_item), 32'(got_exp.last));
        end
      end
      if (in_if.valid && in_if.ready) parse_char(in_if.char_in, in_if.end_of_input);
    end
  end

  // Watchdog: any transfer or register access counts as progress
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("ascii_integer_parser test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed characters, then random runs under several
  // register settings, each started from an idle block
  // ---------------------------------------------------------------------------
  initial begin
    int sent;
    clk_i              = 1'b0;
    rst_ni             = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    in_if.valid        = 1'b0;
    in_if.char_in      = '0;
    in_if.end_of_input = 1'b0;
    out_if.ready       = 1'b0;
    err_cnt            = 0;
    idle_cycles        = 0;
    no_idle            = 1'b0;
    cfg_base_mode      = BM_DETECT;
    cfg_signed         = 1'b1;
    cfg_skip           = 1'b1;
    num_phase          = PH_IDLE;
    num_acc            = '0;
    num_ovf            = 1'b0;
    num_neg            = 1'b0;
    num_base           = B_DEC;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed, reset settings (detect base, signed, skip whitespace):
    // end mark while idle
    push_char('0, 1'b1);
    // sign with no digits reads as zero
    push_text("+ ");
    // negative decimal ended by a character that cannot start a number
    push_text("-80x");
    // hex prefix in both cases of letters, closed by the end mark
    push_text("0XfF");
    push_char(CH_0, 1'b1);
    // octal after a leading zero; the 8 ends it and starts a decimal number
    push_text("078");
    push_char(CH_SP, 1'b1);
    // bytes at both ends of the range
    push_char(8'hFF, 1'b0);
    push_char(8'h00, 1'b0);

    for (int p = 0; p < N_RUNS; p++) begin
      drain();
      if (p == N_RUNS - 1) begin
        write_reg(REG_BASE_MODE, 32'($urandom_range(0, 3)));
        write_reg(REG_SIGNED_MODE, 32'($urandom_range(0, 1)));
        write_reg(REG_SKIP_SPACE, 32'($urandom_range(0, 1)));
      end else begin
        write_reg(REG_BASE_MODE, 32'(RUN_BASE[p]));
        write_reg(REG_SIGNED_MODE, 32'(RUN_SIGNED[p]));
        write_reg(REG_SKIP_SPACE, 32'(RUN_SKIP[p]));
      end
      // one run goes with no idling on either side
      no_idle = (p == 3);
      sent = 0;
      while (sent < RUN_ITEMS) begin
        sent += add_token();
        // halfway through one run, pause the sender until all results are in
        if (p == 4 && sent >= RUN_ITEMS / 2 && sent < RUN_ITEMS / 2 + 8) begin
          drain();
          sent += 8;
        end
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("ascii_integer_parser test passed");
    end else begin
      $display("ascii_integer_parser test failed");
    end
    $finish;
  end

endmodule
